FILE: rtl/wlsh_pkg.sv
`timescale 1ns / 1ps

package wlsh_pkg;

  localparam int DEF_HIST_BINS    = 66;
  localparam int DEF_NUM_SEGMENTS = 10;

  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 10;
  localparam int LEN_W     = 10;
  localparam int SUM_W     = 26;
  localparam int BIN_W     = 7;
  localparam int BAR_W     = 4;
  localparam int IDX_W     = 6;
  localparam int DIVISOR_W = 16;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = 10'd100;

  // bin = sample / 1000 as (sample * ceil(2^26 / 1000)) >> 26, exact for 16-bit samples.
  localparam int                  BIN_SHIFT = 26;
  localparam int                  PROD_W    = SAMPLE_W + 17;
  localparam logic [PROD_W-1:0]   BIN_RECIP = 33'd67109;

  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_BAR_GO,
    ST_BAR_WAIT,
    ST_RPT_RD,
    ST_RPT_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic rd_bin;
    logic upd;
    logic clr_step;
    logic avg_go;
    logic avg_take;
    logic bar_set;
    logic bar_go;
    logic bar_take;
    logic rpt_rd;
    logic rpt_out;
    logic ptr_clr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic win_end;
    logic clr_last;
    logic div_done;
    logic bar_direct;
    logic rpt_last;
  } dp_status_t;

endpackage

FILE: rtl/windowed_level_stats_histogram_unit.sv
`timescale 1ns / 1ps

// A sample that does not close a window goes through READ and WRITE; WRITE may accept the next sample.
// A closing sample keeps busy high through the 26-step bit-serial divider, used for the average
// and, unless the bar level is set directly, again for the bar, and one RAM pair read per result.
// Results come out one per cycle with no stall from the receiver.
// After reset the histogram RAM is cleared pair by pair while busy stays high.
module windowed_level_stats_histogram_unit #(
  parameter int HIST_BINS    = wlsh_pkg::DEF_HIST_BINS,
  parameter int NUM_SEGMENTS = wlsh_pkg::DEF_NUM_SEGMENTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wlsh_pkg::APB_AW-1:0]    paddr,
  input  logic [wlsh_pkg::APB_DW-1:0]    pwdata,
  output logic [wlsh_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic [wlsh_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [wlsh_pkg::SAMPLE_W-1:0]  reference_level_i,
  output logic                          result_valid_o,
  output logic [wlsh_pkg::IDX_W-1:0]     pair_index_o,
  output logic [wlsh_pkg::COUNT_W-1:0]   count_even_o,
  output logic [wlsh_pkg::COUNT_W-1:0]   count_odd_o,
  output logic [wlsh_pkg::SAMPLE_W-1:0]  window_min_o,
  output logic [wlsh_pkg::SAMPLE_W-1:0]  window_max_o,
  output logic [wlsh_pkg::SAMPLE_W-1:0]  window_average_o,
  output logic [wlsh_pkg::BAR_W-1:0]     bar_level_o,
  output logic                          last_o
);
  import wlsh_pkg::*;

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic             len_we;
  logic [LEN_W-1:0] len;
  logic [0:0]       reg_sel;

  assign reg_sel = paddr[APB_AW-1 -: 1];
  assign pready  = 1'b1;
  assign len_we  = psel && penable && pwrite && (reg_sel == REG_WINDOW_LENGTH);
  assign prdata  = (reg_sel == REG_WINDOW_LENGTH) ? APB_DW'(len) : '0;

  wlsh_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .status_i(status),
    .cmd_o   (cmd)
  );

  wlsh_datapath #(
    .HIST_BINS   (HIST_BINS),
    .NUM_SEGMENTS(NUM_SEGMENTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .len_we_i         (len_we),
    .len_wdata_i      (pwdata[LEN_W-1:0]),
    .len_o            (len),
    .sample_i         (sample_i),
    .reference_level_i(reference_level_i),
    .result_valid_o   (result_valid_o),
    .pair_index_o     (pair_index_o),
    .count_even_o     (count_even_o),
    .count_odd_o      (count_odd_o),
    .window_min_o     (window_min_o),
    .window_max_o     (window_max_o),
    .window_average_o (window_average_o),
    .bar_level_o      (bar_level_o),
    .last_o           (last_o)
  );

endmodule

FILE: rtl/wlsh_ram.sv
`timescale 1ns / 1ps

module wlsh_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/wlsh_div.sv
`timescale 1ns / 1ps

module wlsh_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wlsh_pkg::SUM_W-1:0]     dividend_i,
  input  logic [wlsh_pkg::DIVISOR_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [wlsh_pkg::SUM_W-1:0]     quotient_o
);
  import wlsh_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [DIVISOR_W-1:0] dvs_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  always_comb begin
    shifted = {rem_q, quo_q[SUM_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    quo_d   = {quo_q[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(SUM_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/wlsh_datapath.sv
`timescale 1ns / 1ps

module wlsh_datapath #(
  parameter int HIST_BINS    = wlsh_pkg::DEF_HIST_BINS,
  parameter int NUM_SEGMENTS = wlsh_pkg::DEF_NUM_SEGMENTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wlsh_pkg::ctrl_cmd_t            cmd_i,
  output wlsh_pkg::dp_status_t           status_o,
  input  logic                          len_we_i,
  input  logic [wlsh_pkg::LEN_W-1:0]     len_wdata_i,
  output logic [wlsh_pkg::LEN_W-1:0]     len_o,
  input  logic [wlsh_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [wlsh_pkg::SAMPLE_W-1:0]  reference_level_i,
  output logic                          result_valid_o,
  output logic [wlsh_pkg::IDX_W-1:0]     pair_index_o,
  output logic [wlsh_pkg::COUNT_W-1:0]   count_even_o,
  output logic [wlsh_pkg::COUNT_W-1:0]   count_odd_o,
  output logic [wlsh_pkg::SAMPLE_W-1:0]  window_min_o,
  output logic [wlsh_pkg::SAMPLE_W-1:0]  window_max_o,
  output logic [wlsh_pkg::SAMPLE_W-1:0]  window_average_o,
  output logic [wlsh_pkg::BAR_W-1:0]     bar_level_o,
  output logic                          last_o
);
  import wlsh_pkg::*;

  localparam int                 PAIRS     = (HIST_BINS + 1) / 2;
  localparam int                 PAIR_AW   = $clog2(PAIRS);
  localparam int                 PAIR_W    = 2 * COUNT_W;
  localparam logic [BIN_W:0]     BIN_LIMIT = (BIN_W + 1)'(HIST_BINS);
  localparam logic [PAIR_AW-1:0] PAIR_LAST = PAIR_AW'(PAIRS - 1);
  localparam logic [BAR_W-1:0]   BAR_FULL  = BAR_W'(NUM_SEGMENTS);

  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] ref_q;
  logic [BIN_W-1:0]    bin_q, bin_d;
  logic [PROD_W-1:0]   bin_prod;
  logic [SAMPLE_W-1:0] min_q, max_q;
  logic [SUM_W-1:0]    sum_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic [LEN_W-1:0]    len_q;
  logic [LEN_W:0]      len_eff;
  logic [COUNT_W:0]    cnt_next;
  logic [PAIR_AW-1:0]  ptr_q;
  logic [PAIR_AW-1:0]  rd_idx_q;
  logic [SAMPLE_W-1:0] avg_q;
  logic [BAR_W-1:0]    bar_q;
  logic                win_clr;
  logic                in_range;

  logic                ram_we;
  logic [PAIR_AW-1:0]  ram_waddr;
  logic [PAIR_W-1:0]   ram_wdata;
  logic [PAIR_AW-1:0]  ram_raddr;
  logic [PAIR_W-1:0]   ram_rdata;
  logic [COUNT_W-1:0]  even_inc, odd_inc;

  logic                div_start;
  logic [SUM_W-1:0]    div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic [SUM_W-1:0]    seg_prod;

  logic                valid_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic [COUNT_W-1:0]  out_even_q, out_odd_q;
  logic [SAMPLE_W-1:0] out_min_q, out_max_q, out_avg_q;
  logic [BAR_W-1:0]    out_bar_q;
  logic                out_last_q;

  always_comb begin
    bin_prod = PROD_W'(sample_q) * BIN_RECIP;
    bin_d    = bin_prod[BIN_SHIFT +: BIN_W];
    in_range = {1'b0, bin_q} < BIN_LIMIT;
    len_eff  = (len_q == '0) ? (LEN_W + 1)'(1) : {1'b0, len_q};
    cnt_next = {1'b0, cnt_q} + 1'b1;
    even_inc = ram_rdata[COUNT_W-1:0] + 1'b1;
    odd_inc  = ram_rdata[PAIR_W-1:COUNT_W] + 1'b1;
    win_clr  = cmd_i.rpt_out && status_o.rpt_last;
  end

  always_comb begin
    status_o.win_end    = cnt_next >= len_eff;
    status_o.clr_last   = ptr_q == PAIR_LAST;
    status_o.div_done   = div_done;
    status_o.bar_direct = (avg_q > ref_q) || (ref_q == '0);
    status_o.rpt_last   = rd_idx_q == PAIR_LAST;
  end

  always_comb begin
    ram_raddr = cmd_i.rd_bin ? PAIR_AW'(bin_d >> 1) : ptr_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = '0;
    if (cmd_i.upd) begin
      ram_we    = in_range;
      ram_waddr = PAIR_AW'(bin_q >> 1);
      ram_wdata = bin_q[0] ? {odd_inc, ram_rdata[COUNT_W-1:0]}
                           : {ram_rdata[PAIR_W-1:COUNT_W], even_inc};
    end else if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q;
    end else if (cmd_i.rpt_out) begin
      ram_we    = 1'b1;
      ram_waddr = rd_idx_q;
    end
  end

  wlsh_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(PAIRS)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    seg_prod     = SUM_W'(NUM_SEGMENTS) * SUM_W'(avg_q);
    div_start    = cmd_i.avg_go || cmd_i.bar_go;
    div_dividend = cmd_i.avg_go ? sum_q : seg_prod;
    div_divisor  = cmd_i.avg_go ? DIVISOR_W'(cnt_q) : ref_q;
  end

  wlsh_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LEN_RESET;
      min_q    <= '1;
      max_q    <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      ptr_q    <= '0;
      rd_idx_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      if (len_we_i) begin
        len_q <= len_wdata_i;
      end
      if (win_clr) begin
        min_q <= '1;
        max_q <= '0;
        sum_q <= '0;
        cnt_q <= '0;
      end else if (cmd_i.upd) begin
        if (sample_q < min_q) begin
          min_q <= sample_q;
        end
        if (sample_q > max_q) begin
          max_q <= sample_q;
        end
        sum_q <= sum_q + SUM_W'(sample_q);
        cnt_q <= cnt_next[COUNT_W-1:0];
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.clr_step || cmd_i.rpt_rd || cmd_i.rpt_out) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.rpt_rd || cmd_i.rpt_out) begin
        rd_idx_q <= ptr_q;
      end
      valid_q <= cmd_i.rpt_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
      ref_q    <= reference_level_i;
    end
    if (cmd_i.rd_bin) begin
      bin_q <= bin_d;
    end
    if (cmd_i.avg_take) begin
      avg_q <= div_quo[SAMPLE_W-1:0];
    end
    if (cmd_i.bar_set) begin
      bar_q <= (avg_q > ref_q) ? BAR_FULL : '0;
    end else if (cmd_i.bar_take) begin
      bar_q <= div_quo[BAR_W-1:0];
    end
    if (cmd_i.rpt_out) begin
      out_idx_q  <= IDX_W'(rd_idx_q);
      out_even_q <= ram_rdata[COUNT_W-1:0];
      out_odd_q  <= ram_rdata[PAIR_W-1:COUNT_W];
      out_min_q  <= min_q;
      out_max_q  <= max_q;
      out_avg_q  <= avg_q;
      out_bar_q  <= bar_q;
      out_last_q <= status_o.rpt_last;
    end
  end

  assign len_o            = len_q;
  assign result_valid_o   = valid_q;
  assign pair_index_o     = out_idx_q;
  assign count_even_o     = out_even_q;
  assign count_odd_o      = out_odd_q;
  assign window_min_o     = out_min_q;
  assign window_max_o     = out_max_q;
  assign window_average_o = out_avg_q;
  assign bar_level_o      = out_bar_q;
  assign last_o           = out_last_q;

endmodule

FILE: rtl/wlsh_ctrl.sv
`timescale 1ns / 1ps

module wlsh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  wlsh_pkg::dp_status_t status_i,
  output wlsh_pkg::ctrl_cmd_t  cmd_o
);
  import wlsh_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          cmd_o.ptr_clr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_bin = 1'b1;
        state_d      = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.upd = 1'b1;
        if (status_i.win_end) begin
          state_d = ST_AVG_GO;
        end else begin
          busy = 1'b0;
          if (start) begin
            cmd_o.accept = 1'b1;
            state_d      = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_AVG_GO: begin
        cmd_o.avg_go = 1'b1;
        state_d      = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.avg_take = 1'b1;
          state_d        = ST_BAR_GO;
        end
      end
      ST_BAR_GO: begin
        if (status_i.bar_direct) begin
          cmd_o.bar_set = 1'b1;
          state_d       = ST_RPT_RD;
        end else begin
          cmd_o.bar_go = 1'b1;
          state_d      = ST_BAR_WAIT;
        end
      end
      ST_BAR_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.bar_take = 1'b1;
          state_d        = ST_RPT_RD;
        end
      end
      ST_RPT_RD: begin
        cmd_o.rpt_rd = 1'b1;
        state_d      = ST_RPT_OUT;
      end
      ST_RPT_OUT: begin
        cmd_o.rpt_out = 1'b1;
        if (status_i.rpt_last) begin
          cmd_o.ptr_clr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import wlsh_pkg::*;

  localparam int PAIRS         = (DEF_HIST_BINS + 1) / 2;
  localparam int BIN_WIDTH     = 1000;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 2000;
  localparam int TOTAL_ITEMS   = 410;
  localparam int FINAL_LENGTH  = 150;
  localparam logic [APB_AW-1:0] WINDOW_LENGTH_ADDR = APB_AW'({REG_WINDOW_LENGTH, 2'b00});
  // Byte address of register index 1, which does not exist.
  localparam logic [APB_AW-1:0] UNMAPPED_ADDR      = APB_AW'(4);

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0] ref_level;
  } sample_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]    pair_index;
    logic [COUNT_W-1:0]  count_even;
    logic [COUNT_W-1:0]  count_odd;
    logic [SAMPLE_W-1:0] window_min;
    logic [SAMPLE_W-1:0] window_max;
    logic [SAMPLE_W-1:0] window_average;
    logic [BAR_W-1:0]    bar_level;
    logic                last;
  } bin_pair_t;

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                start             = 1'b0;
  logic                busy;
  logic                psel              = 1'b0;
  logic                penable           = 1'b0;
  logic                pwrite            = 1'b0;
  logic [APB_AW-1:0]   paddr             = '0;
  logic [APB_DW-1:0]   pwdata            = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic [SAMPLE_W-1:0] sample_i          = '0;
  logic [SAMPLE_W-1:0] reference_level_i = '0;
  logic                result_valid_o;
  logic [IDX_W-1:0]    pair_index_o;
  logic [COUNT_W-1:0]  count_even_o;
  logic [COUNT_W-1:0]  count_odd_o;
  logic [SAMPLE_W-1:0] window_min_o;
  logic [SAMPLE_W-1:0] window_max_o;
  logic [SAMPLE_W-1:0] window_average_o;
  logic [BAR_W-1:0]    bar_level_o;
  logic                last_o;

  logic [LEN_W-1:0]    cfg_window_length = LEN_RESET;
  logic [COUNT_W-1:0]  bin_count [DEF_HIST_BINS];
  logic [SAMPLE_W-1:0] level_min;
  logic [SAMPLE_W-1:0] level_max;
  logic [SUM_W-1:0]    level_sum;
  logic [LEN_W:0]      level_taken;

  sample_cmd_t pending_samples [$];
  bin_pair_t   expected_pairs [$];

  int unsigned gap_left         = 0;
  int unsigned samples_queued   = 0;
  int unsigned samples_accepted = 0;
  int unsigned windows_reported = 0;
  int unsigned pairs_checked    = 0;
  int unsigned mismatches       = 0;
  int unsigned stall_cycles     = 0;
  bit          idling_on        = 1'b1;

  windowed_level_stats_histogram_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .sample_i         (sample_i),
    .reference_level_i(reference_level_i),
    .result_valid_o   (result_valid_o),
    .pair_index_o     (pair_index_o),
    .count_even_o     (count_even_o),
    .count_odd_o      (count_odd_o),
    .window_min_o     (window_min_o),
    .window_max_o     (window_max_o),
    .window_average_o (window_average_o),
    .bar_level_o      (bar_level_o),
    .last_o           (last_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic void clear_window();
    foreach (bin_count[i]) bin_count[i] = '0;
    level_min   = '1;
    level_max   = '0;
    level_sum   = '0;
    level_taken = '0;
  endfunction

  function automatic void accumulate_sample(input sample_cmd_t cmd);
    logic [LEN_W:0]      needed;
    logic [SAMPLE_W-1:0] average;
    logic [BAR_W-1:0]    bar;
    int unsigned         bin;
    int unsigned         quotient;
    bin_pair_t           pair;
    needed = (cfg_window_length == '0) ? (LEN_W + 1)'(1) : {1'b0, cfg_window_length};
    if (cmd.level > level_max) level_max = cmd.level;
    if (cmd.level < level_min) level_min = cmd.level;
    level_sum = level_sum + SUM_W'(cmd.level);
    bin = cmd.level / BIN_WIDTH;
    if (bin < DEF_HIST_BINS) bin_count[bin] = bin_count[bin] + 1'b1;
    level_taken = level_taken + 1'b1;
    if (level_taken < needed) return;
    quotient = int'(level_sum) / int'(level_taken);
    average  = quotient[SAMPLE_W-1:0];
    if (average > cmd.ref_level) begin
      bar = BAR_W'(DEF_NUM_SEGMENTS);
    end else if (cmd.ref_level == '0) begin
      bar = '0;
    end else begin
      bar = BAR_W'((DEF_NUM_SEGMENTS * int'(average)) / int'(cmd.ref_level));
    end
    for (int k = 0; k < PAIRS; k++) begin
      pair.pair_index     = IDX_W'(k);
      pair.count_even     = bin_count[2*k];
      pair.count_odd      = (2*k + 1 < DEF_HIST_BINS) ? bin_count[2*k + 1] : '0;
      pair.window_min     = level_min;
      pair.window_max     = level_max;
      pair.window_average = average;
      pair.bar_level      = bar;
      pair.last           = (k == PAIRS - 1);
      expected_pairs.push_back(pair);
    end
    windows_reported++;
    clear_window();
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void queue_sample(input logic [SAMPLE_W-1:0] level,
                                       input logic [SAMPLE_W-1:0] ref_level);
    pending_samples.push_back('{level, ref_level});
    samples_queued++;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_level(input int unsigned base);
    case ($urandom_range(0, 9))
      0:       return SAMPLE_W'($urandom_range(1, 65) * BIN_WIDTH - $urandom_range(0, 1));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2, 3, 4: return SAMPLE_W'(base + $urandom_range(0, 1999));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_reference(input int unsigned base);
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return SAMPLE_W'($urandom_range(1, 16));
      3, 4, 5: return SAMPLE_W'(base + $urandom_range(0, 2000));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] random_window_length();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return LEN_W'(1);
      2:       return LEN_W'(2);
      7:       return LEN_W'($urandom_range(17, 40));
      default: return LEN_W'($urandom_range(3, 16));
    endcase
  endfunction

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == WINDOW_LENGTH_ADDR) cfg_window_length = data[LEN_W-1:0];
  endtask

  task automatic check_window_length_readback();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= WINDOW_LENGTH_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("window_length", cfg_window_length, prdata[LEN_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window_length(input logic [LEN_W-1:0] length);
    logic [APB_DW-1:0] data;
    data              = $urandom;
    data[LEN_W-1:0]   = length;
    apb_write(WINDOW_LENGTH_ADDR, data);
    check_window_length_readback();
    @(negedge clk_i);
  endtask

  task automatic wait_until_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || start || expected_pairs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    logic        next_start;
    sample_cmd_t cmd;
    if (rst_ni) begin
      next_start = start;
      if (start && !busy) begin
        accumulate_sample('{sample_i, reference_level_i});
        samples_accepted++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_samples.size() != 0) begin
          if (idling_on && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 11);
          end else begin
            cmd = pending_samples.pop_front();
            sample_i          <= cmd.level;
            reference_level_i <= cmd.ref_level;
            next_start = 1'b1;
          end
        end
      end
      start <= next_start;
    end
  end

  always @(posedge clk_i) begin
    bin_pair_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_pairs.size() == 0) begin
        $error("Unexpected result transaction with pair_index %0d", pair_index_o);
        mismatches++;
      end else begin
        want = expected_pairs.pop_front();
        check_field("pair_index", want.pair_index, pair_index_o);
        check_field("count_even", want.count_even, count_even_o);
        check_field("count_odd", want.count_odd, count_odd_o);
        check_field("window_min", want.window_min, window_min_o);
        check_field("window_max", want.window_max, window_max_o);
        check_field("window_average", want.window_average, window_average_o);
        check_field("bar_level", want.bar_level, bar_level_o);
        check_field("last", want.last, last_o);
        pairs_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [LEN_W-1:0] length;
    int unsigned      span;
    int unsigned      count;
    int unsigned      base;

    clear_window();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i); while (busy);
    check_window_length_readback();

    // One window at the length left by reset.
    @(negedge clk_i);
    base = $urandom_range(0, 63535);
    repeat (LEN_RESET) queue_sample(random_level(base), random_reference(base));
    wait_until_drained();

    // Field extremes, bin edges and every way the bar level is formed.
    set_window_length(LEN_W'(1));
    queue_sample(16'd0, 16'd0);
    queue_sample(16'd0, 16'd65535);
    queue_sample(16'd65535, 16'd65535);
    queue_sample(16'd65535, 16'd65534);
    queue_sample(16'd65535, 16'd0);
    queue_sample(16'd999, 16'd1000);
    queue_sample(16'd1000, 16'd999);
    queue_sample(16'd64999, 16'd65535);
    queue_sample(16'd65000, 16'd65001);
    queue_sample(16'd1, 16'd10);
    queue_sample(16'd32768, 16'd65535);
    queue_sample(16'd6553, 16'd65535);
    wait_until_drained();

    // A zero length acts as a length of one.
    set_window_length('0);
    queue_sample(16'd500, 16'd3000);
    queue_sample(16'd65535, 16'd1);
    queue_sample(16'd1000, 16'd1000);
    wait_until_drained();

    set_window_length(LEN_W'(3));
    queue_sample(16'd5, 16'd4);
    queue_sample(16'd5, 16'd4);
    queue_sample(16'd5, 16'd4);
    queue_sample(16'd0, 16'd65535);
    queue_sample(16'd65535, 16'd65535);
    queue_sample(16'd1, 16'd65535);
    wait_until_drained();

    // Shrinking the length below the samples already taken ends the window with the next sample.
    set_window_length('1);
    queue_sample(16'd1234, 16'd0);
    queue_sample(16'd4321, 16'd100);
    queue_sample(16'd65535, 16'd40000);
    queue_sample(16'd0, 16'd2);
    queue_sample(16'd30000, 16'd65535);
    wait_until_drained();
    apb_write(UNMAPPED_ADDR, 32'hFFFF_FC02);
    check_window_length_readback();
    set_window_length(LEN_W'(2));
    queue_sample(16'd20000, 16'd25000);
    wait_until_drained();

    while (samples_queued < TOTAL_ITEMS - FINAL_LENGTH) begin
      idling_on = ($urandom_range(0, 3) != 0);
      length    = random_window_length();
      set_window_length(length);
      span  = (length == '0) ? 1 : length;
      count = span * $urandom_range(1, 3);
      if ($urandom_range(0, 2) == 0) count += $urandom_range(0, span - 1);
      base = $urandom_range(0, 63535);
      repeat (count) queue_sample(random_level(base), random_reference(base));
      wait_until_drained();
    end

    // A long window with every sample in the top bin and no idling.
    idling_on = 1'b0;
    set_window_length(LEN_W'(FINAL_LENGTH));
    repeat (FINAL_LENGTH) queue_sample(SAMPLE_W'(65000 + $urandom_range(0, 535)), 16'hFFFF);
    wait_until_drained();

    $display("Run covered %0d samples in %0d window reports, %0d bin pair results checked.",
             samples_accepted, windows_reported, pairs_checked);
    $display("Window lengths 0, 1, 2, 3, 100, %0d, 1023 and random lengths up to 40.",
             FINAL_LENGTH);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
